[design/pcr_pkg.sv]
`default_nettype none

package pcr_pkg;

    // Sequencer state encoding.
    localparam int STATE_BITS = 3;
    typedef logic [STATE_BITS-1:0] state_t;

    localparam state_t ST_IDLE   = 3'd0;
    localparam state_t ST_CAND   = 3'd1;
    localparam state_t ST_TEST   = 3'd2;
    localparam state_t ST_DIV    = 3'd3;
    localparam state_t ST_CHECK  = 3'd4;
    localparam state_t ST_NEXT   = 3'd5;
    localparam state_t ST_FINISH = 3'd6;

    // Smallest prime and first trial divisor.
    localparam int FIRST_DIVISOR = 2;

endpackage

`default_nettype wire

[design/prime_count_in_range.sv]
// Prime counter over an inclusive range of unsigned integers.
//
// The input channel (in_valid / in_stall) carries one transaction holding
// range_start and range_end. The output channel (out_valid / out_stall)
// returns one transaction per input holding prime_count, the number of primes
// p with range_start <= p <= range_end. An empty range gives zero.
//
// Each candidate is tested by trial division with divisors 2, 3, ... while
// the divisor squared does not exceed the candidate. One restoring
// shift-subtract remainder unit is shared by all trials and resolves one bit
// per cycle. A candidate passes through ST_CAND, then per trial ST_TEST,
// ST_DIV and ST_CHECK, then ST_NEXT; a prime ends with a further ST_TEST,
// and 0 and 1 skip the trials. A transaction is accepted in ST_IDLE and its
// count is handed off in ST_FINISH.
//
// in_stall is high while a range is being worked on. A finished count sits in
// the output register until taken; if the receiver still stalls the previous
// result, the sequencer holds the new count until the register frees.
// Reset (rst_n low) returns the sequencer to idle and drops out_valid.
`default_nettype none

module prime_count_in_range #(
    parameter int VALUE_BITS = 16
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  wire [VALUE_BITS-1:0] range_start,
    input  wire [VALUE_BITS-1:0] range_end,
    output logic                 out_valid,
    input  wire                  out_stall,
    output logic [VALUE_BITS:0]  prime_count
);

    localparam int CNT_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    pcr_pkg::state_t state_reg, state_next;

    logic [VALUE_BITS-1:0] n_reg, n_next;
    logic [VALUE_BITS-1:0] hi_reg, hi_next;
    logic [VALUE_BITS:0]   count_reg, count_next;
    logic [VALUE_BITS-1:0] d_reg, d_next;
    logic [VALUE_BITS:0]   sq_reg, sq_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS-1:0] dividend_reg, dividend_next;
    logic [CNT_BITS-1:0]   bit_cnt_reg, bit_cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS:0]   result_reg, result_next;

    logic                  in_accept;
    logic                  out_free;
    logic [VALUE_BITS:0]   rem_shift;
    logic                  rem_ge;

    assign in_stall    = (state_reg != pcr_pkg::ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign prime_count = result_reg;
    assign in_accept   = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;

    // Shared remainder step: bring in the next dividend bit, subtract if it fits.
    assign rem_shift = {rem_reg, dividend_reg[VALUE_BITS-1]};
    assign rem_ge    = (rem_shift >= {1'b0, d_reg});

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        hi_next        = hi_reg;
        count_next     = count_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        rem_next       = rem_reg;
        dividend_next  = dividend_reg;
        bit_cnt_next   = bit_cnt_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            pcr_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    n_next     = range_start;
                    hi_next    = range_end;
                    count_next = '0;
                    if (range_start > range_end)
                    begin
                        state_next = pcr_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = pcr_pkg::ST_CAND;
                    end
                end
            end
            pcr_pkg::ST_CAND:
            begin
                // Zero and one are not prime.
                if ({1'b0, n_reg} < (VALUE_BITS + 1)'(pcr_pkg::FIRST_DIVISOR))
                begin
                    state_next = pcr_pkg::ST_NEXT;
                end
                else
                begin
                    d_next     = VALUE_BITS'(pcr_pkg::FIRST_DIVISOR);
                    sq_next    = (VALUE_BITS + 1)'(pcr_pkg::FIRST_DIVISOR *
                                                   pcr_pkg::FIRST_DIVISOR);
                    state_next = pcr_pkg::ST_TEST;
                end
            end
            pcr_pkg::ST_TEST:
            begin
                // Divisor squared beyond the candidate: no factor found, prime.
                if (sq_reg > {1'b0, n_reg})
                begin
                    count_next = count_reg + 1'b1;
                    state_next = pcr_pkg::ST_NEXT;
                end
                else
                begin
                    rem_next      = '0;
                    dividend_next = n_reg;
                    bit_cnt_next  = CNT_BITS'(VALUE_BITS - 1);
                    state_next    = pcr_pkg::ST_DIV;
                end
            end
            pcr_pkg::ST_DIV:
            begin
                if (rem_ge)
                begin
                    rem_next = VALUE_BITS'(rem_shift - {1'b0, d_reg});
                end
                else
                begin
                    rem_next = rem_shift[VALUE_BITS-1:0];
                end
                dividend_next = {dividend_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next  = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    state_next = pcr_pkg::ST_CHECK;
                end
            end
            pcr_pkg::ST_CHECK:
            begin
                // Exact divisor: composite. Otherwise try the next divisor,
                // updating its square as (d+1)^2 = d^2 + 2d + 1.
                if (rem_reg == '0)
                begin
                    state_next = pcr_pkg::ST_NEXT;
                end
                else
                begin
                    d_next     = d_reg + 1'b1;
                    sq_next    = sq_reg + {d_reg, 1'b1};
                    state_next = pcr_pkg::ST_TEST;
                end
            end
            pcr_pkg::ST_NEXT:
            begin
                if (n_reg == hi_reg)
                begin
                    state_next = pcr_pkg::ST_FINISH;
                end
                else
                begin
                    n_next     = n_reg + 1'b1;
                    state_next = pcr_pkg::ST_CAND;
                end
            end
            pcr_pkg::ST_FINISH:
            begin
                // Hand the count to the output register once it is free.
                if (out_free)
                begin
                    result_next    = count_reg;
                    out_valid_next = 1'b1;
                    state_next     = pcr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pcr_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        hi_reg       <= hi_next;
        count_reg    <= count_next;
        d_reg        <= d_next;
        sq_reg       <= sq_next;
        rem_reg      <= rem_next;
        dividend_reg <= dividend_next;
        bit_cnt_reg  <= bit_cnt_next;
        result_reg   <= result_next;
    end

`ifndef ASSERT_OFF
    // An accepted range always starts work.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg != pcr_pkg::ST_IDLE))
        else $error("sequencer idle after accepting a range");

    // The running remainder stays below the divisor.
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pcr_pkg::ST_DIV || state_reg == pcr_pkg::ST_CHECK)
            |-> (rem_reg < d_reg))
        else $error("remainder not below divisor");

    // Trial divisors never drop below two.
    a_div_min: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pcr_pkg::ST_DIV || state_reg == pcr_pkg::ST_TEST)
            |-> (d_reg >= VALUE_BITS'(pcr_pkg::FIRST_DIVISOR)))
        else $error("trial divisor below two");

    // A count is only loaded when the output register is free.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pcr_pkg::ST_FINISH && out_valid_reg && out_stall)
            |=> (state_reg == pcr_pkg::ST_FINISH))
        else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire
